@@ hdl/fdj_pkg.sv @@
// Shared types and constants of the frame drop and jitter generator.
package fdj_pkg;

    localparam logic [63:0] GOLDEN_INC  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] DROP_SALT   = 64'ha0761d6478bd642f;
    localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam logic [63:0] NS_PER_S    = 64'd1000000000;
    localparam logic [6:0]  PERCENT_ALL = 7'd100;

    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int DIVISOR_W           = 32;
    localparam int PERIOD_W            = 30;
    localparam int ADDR_W              = 6;

    // Register indexes (byte address / 8)
    localparam logic [2:0] REG_FPS      = 3'd0;
    localparam logic [2:0] REG_JITTER   = 3'd1;
    localparam logic [2:0] REG_SIZE     = 3'd2;
    localparam logic [2:0] REG_SEED     = 3'd3;
    localparam logic [2:0] REG_INTERVAL = 3'd4;
    localparam logic [2:0] REG_PERCENT  = 3'd5;
    localparam logic [2:0] REG_BURST    = 3'd6;

    typedef struct packed {
        logic [16:0] frames_per_second;
        logic [19:0] max_jitter_us;
        logic [31:0] frame_size;
        logic [63:0] hash_seed;
        logic [15:0] periodic_drop_interval;
        logic [6:0]  drop_chance_percent;
        logic [15:0] burst_length;
    } cfg_t;

    typedef struct packed {
        logic [63:0] id;
        logic        first_of_pull;
    } frame_item_t;

endpackage

@@ hdl/fdj_div.sv @@
// Restoring divider, one quotient bit per cycle.
module fdj_div #(
    parameter int N = 64,
    parameter int D = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient,
    output logic [D-1:0] remainder
);
    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [N-1:0]     quo_reg, quo_next;
    logic [D-1:0]     rem_reg, rem_next;
    logic [D-1:0]     dvs_reg, dvs_next;
    logic [D:0]       trial;
    logic             ge;

    assign trial = {rem_reg, quo_reg[N-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_W'(N);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // shift one dividend bit in, subtract when it fits
            rem_next = ge ? D'(trial - {1'b0, dvs_reg}) : trial[D-1:0];
            quo_next = {quo_reg[N-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

@@ hdl/fdj_queue.sv @@
// Small register queue between the front and back parts.
module fdj_queue #(
    parameter int DEPTH = fdj_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fdj_pkg::frame_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output fdj_pkg::frame_item_t pop_item,
    output logic                 not_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fdj_pkg::frame_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign full      = cnt_reg == CNT_W'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign pop_item  = entry_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= bump(wr_reg);
            if (pop)
                rd_reg <= bump(rd_reg);
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_item;
    end
endmodule

@@ hdl/fdj_front.sv @@
// Front part: accept frame ticks and assign frame ids.
module fdj_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 restart_stream,
    input  logic                 first_of_pull,
    input  logic                 q_full,
    output logic                 push,
    output fdj_pkg::frame_item_t push_item
);
    logic [63:0] next_id_reg, next_id_next;
    logic [63:0] id;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    // restart comes first: the id restarts at zero for this frame
    assign id       = restart_stream ? 64'd0 : next_id_reg;

    assign push_item.id            = id;
    assign push_item.first_of_pull = first_of_pull;

    assign next_id_next = push ? id + 64'd1 : next_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            next_id_reg <= '0;
        else
            next_id_reg <= next_id_next;
    end
endmodule

@@ hdl/fdj_back.sv @@
// Back part: timestamp, jitter and drop decision for one frame at a time.
module fdj_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fdj_pkg::cfg_t        cfg,
    input  logic                 q_not_empty,
    input  fdj_pkg::frame_item_t q_item,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [63:0]          frame_number,
    output logic signed [63:0]   timestamp_ns,
    output logic [31:0]          frame_bytes,
    output logic                 dropped
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_PER_DIV, ST_PER_MUL, ST_ID_MUL,
        ST_J_MIX1, ST_J_MIX2, ST_J_DIV,
        ST_P_MIX1, ST_P_MIX2, ST_P_MOD,
        ST_R_DIV, ST_FINISH
    } state_t;

    localparam int DW = fdj_pkg::DIVISOR_W;
    localparam int PW = fdj_pkg::PERIOD_W;

    state_t          state_reg, state_next;
    logic [63:0]     id_reg, id_next;
    logic [PW-1:0]   period_reg, period_next;
    logic [63:0]     x_reg, x_next;
    logic [63:0]     w_reg, w_next;
    logic [63:0]     acc_reg, acc_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [63:0]     ts_reg, ts_next;
    logic            trig_reg, trig_next;
    logic            dgo_reg, dgo_next;
    logic [15:0]     burst_reg, burst_next;
    logic [63:0]     prev_ts_reg, prev_ts_next;
    logic            prev_ok_reg, prev_ok_next;
    logic            ov_reg, ov_next;
    logic [63:0]     o_id_reg, o_id_next;
    logic [63:0]     o_ts_reg, o_ts_next;
    logic [31:0]     o_size_reg, o_size_next;
    logic            o_drop_reg, o_drop_next;

    logic            div_start, div_done, div_ready;
    logic [63:0]     div_dividend, div_quo;
    logic [DW-1:0]   div_divisor, div_rem;

    logic [63:0]     mul_a, mul_b, mul_sum;
    logic [15:0]     chunk;
    logic            mul_last;

    logic [23:0]     pct_fold;
    logic [16:0]     pct_t;
    logic [33:0]     pct_prod;
    logic [11:0]     pct_q;
    logic [16:0]     pct_q100;
    logic [16:0]     pct_r;
    logic [16:0]     pct_mod;

    logic [63:0]     jit, ts_fix;
    logic [15:0]     burst_tmp;
    logic            drop_now;

    fdj_div #(.N(64), .D(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    function automatic logic [63:0] mix_pre(input logic [63:0] v);
        logic [63:0] s;
        s = v + fdj_pkg::GOLDEN_INC;
        return s ^ (s >> 30);
    endfunction

    // shared multiplier: 64 x 16 partial product per cycle, accumulated chunk by chunk
    always_comb
    begin
        case (state_reg)
            ST_PER_MUL:             begin mul_a = id_reg; mul_b = 64'(period_reg); end
            ST_ID_MUL:              begin mul_a = id_reg; mul_b = fdj_pkg::GOLDEN_INC; end
            ST_J_MIX1, ST_P_MIX1:   begin mul_a = w_reg;  mul_b = fdj_pkg::MIX_MUL_A; end
            ST_J_MIX2, ST_P_MIX2:   begin mul_a = w_reg;  mul_b = fdj_pkg::MIX_MUL_B; end
            default:                begin mul_a = w_reg;  mul_b = '0; end
        endcase
    end

    assign chunk    = mul_b[{cnt_reg, 4'b0000} +: 16];
    assign mul_sum  = ((cnt_reg == 2'd0) ? 64'd0 : acc_reg)
                    + ((mul_a * 64'(chunk)) << {cnt_reg, 4'b0000});
    assign mul_last = cnt_reg == 2'd3;

    // hash mod 100 in three steps: fold the 16-bit chunks by their residues
    // (2^16, 2^32, 2^48 leave 36, 96, 56), fold once more, then take the
    // quotient by a reciprocal multiply and fix the remainder by one subtract
    assign pct_fold = 24'(w_reg[15:0]) + 24'(w_reg[31:16]) * 24'd36
                    + 24'(w_reg[47:32]) * 24'd96 + 24'(w_reg[63:48]) * 24'd56;
    assign pct_t    = 17'(acc_reg[15:0]) + 17'(acc_reg[23:16]) * 17'd36;
    assign pct_prod = 34'(pct_t) * 34'd41943;
    assign pct_q    = pct_prod[33:22];
    assign pct_q100 = 17'(acc_reg[28:17]) * 17'd100;
    assign pct_r    = acc_reg[16:0] - pct_q100;
    assign pct_mod  = (pct_r >= 17'd100) ? pct_r - 17'd100 : pct_r;

    // shared divider operands
    always_comb
    begin
        case (state_reg)
            ST_PER_DIV:
            begin
                div_dividend = fdj_pkg::NS_PER_S;
                div_divisor  = (cfg.frames_per_second == '0) ? DW'(1)
                                                            : DW'(cfg.frames_per_second);
            end
            ST_J_DIV:
            begin
                div_dividend = w_reg;
                div_divisor  = DW'({cfg.max_jitter_us, 1'b1});
            end
            default:
            begin
                div_dividend = id_reg + 64'd1;
                div_divisor  = DW'(cfg.periodic_drop_interval);
            end
        endcase
    end

    assign div_start = (state_reg == ST_PER_DIV || state_reg == ST_J_DIV
                        || state_reg == ST_R_DIV) && !dgo_reg;

    // only a divide started from the current state counts as finished
    assign div_ready = div_done && dgo_reg;

    assign jit = 64'(div_rem) - 64'(cfg.max_jitter_us);

    // monotonic fix and burst bookkeeping of the finished frame
    always_comb
    begin
        ts_fix = ts_reg;
        if (prev_ok_reg && ($signed(ts_reg) <= $signed(prev_ts_reg)))
            ts_fix = prev_ts_reg + 64'd1000;
        burst_tmp = burst_reg;
        if (cfg.burst_length != '0 && trig_reg && burst_reg < cfg.burst_length)
            burst_tmp = cfg.burst_length;
        drop_now = trig_reg;
        if (cfg.burst_length != '0 && burst_tmp != '0)
        begin
            drop_now  = 1'b1;
            burst_tmp = burst_tmp - 16'd1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        id_next      = id_reg;
        period_next  = period_reg;
        x_next       = x_reg;
        w_next       = w_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        ts_next      = ts_reg;
        trig_next    = trig_reg;
        dgo_next     = dgo_reg;
        burst_next   = burst_reg;
        prev_ts_next = prev_ts_reg;
        prev_ok_next = prev_ok_reg;
        ov_next      = ov_reg && out_stall;
        o_id_next    = o_id_reg;
        o_ts_next    = o_ts_reg;
        o_size_next  = o_size_reg;
        o_drop_next  = o_drop_reg;
        pop          = 1'b0;

        if (div_start)
            dgo_next = 1'b1;

        if (state_reg == ST_PER_MUL || state_reg == ST_ID_MUL || state_reg == ST_J_MIX1
            || state_reg == ST_J_MIX2 || state_reg == ST_P_MIX1 || state_reg == ST_P_MIX2)
        begin
            acc_next = mul_sum;
            cnt_next = cnt_reg + 2'd1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    pop       = 1'b1;
                    id_next   = q_item.id;
                    trig_next = 1'b0;
                    if (q_item.first_of_pull)
                    begin
                        burst_next   = '0;
                        prev_ts_next = '0;
                        prev_ok_next = 1'b0;
                    end
                    state_next = ST_PER_DIV;
                end
            end
            ST_PER_DIV:
            begin
                if (div_ready)
                begin
                    dgo_next    = 1'b0;
                    period_next = div_quo[PW-1:0];
                    cnt_next    = '0;
                    state_next  = ST_PER_MUL;
                end
            end
            ST_PER_MUL:
            begin
                if (mul_last)
                begin
                    ts_next    = mul_sum;
                    state_next = ST_ID_MUL;
                end
            end
            ST_ID_MUL:
            begin
                if (mul_last)
                begin
                    x_next = mul_sum;
                    if (cfg.max_jitter_us != '0)
                    begin
                        w_next     = mix_pre(cfg.hash_seed ^ mul_sum);
                        state_next = ST_J_MIX1;
                    end
                    else
                        state_next = ST_J_DIV;
                end
            end
            ST_J_MIX1, ST_P_MIX1:
            begin
                if (mul_last)
                begin
                    w_next     = mul_sum ^ (mul_sum >> 27);
                    state_next = (state_reg == ST_J_MIX1) ? ST_J_MIX2 : ST_P_MIX2;
                end
            end
            ST_J_MIX2, ST_P_MIX2:
            begin
                if (mul_last)
                begin
                    w_next     = mul_sum ^ (mul_sum >> 31);
                    state_next = (state_reg == ST_J_MIX2) ? ST_J_DIV : ST_P_MOD;
                end
            end
            ST_J_DIV:
            begin
                // also the landing point when jitter is off: skip the divide
                if (cfg.max_jitter_us == '0 || div_ready)
                begin
                    dgo_next = 1'b0;
                    if (cfg.max_jitter_us != '0)
                        ts_next = ts_reg + (jit << 10) - (jit << 4) - (jit << 3);
                    if (cfg.drop_chance_percent == '0)
                        state_next = ST_R_DIV;
                    else if (cfg.drop_chance_percent >= fdj_pkg::PERCENT_ALL)
                    begin
                        trig_next  = 1'b1;
                        state_next = ST_R_DIV;
                    end
                    else
                    begin
                        w_next     = mix_pre((cfg.hash_seed ^ fdj_pkg::DROP_SALT) + x_reg);
                        cnt_next   = '0;
                        state_next = ST_P_MIX1;
                    end
                end
            end
            ST_P_MOD:
            begin
                case (cnt_reg)
                    2'd0:
                    begin
                        acc_next = 64'(pct_fold);
                        cnt_next = 2'd1;
                    end
                    2'd1:
                    begin
                        acc_next = 64'({pct_q, pct_t});
                        cnt_next = 2'd2;
                    end
                    default:
                    begin
                        if (pct_mod < 17'(cfg.drop_chance_percent))
                            trig_next = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_R_DIV;
                    end
                endcase
            end
            ST_R_DIV:
            begin
                if (cfg.periodic_drop_interval == '0 || div_ready)
                begin
                    dgo_next = 1'b0;
                    if (cfg.periodic_drop_interval != '0 && div_rem == '0)
                        trig_next = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next      = 1'b1;
                    o_id_next    = id_reg;
                    o_ts_next    = ts_fix;
                    o_size_next  = drop_now ? 32'd0 : cfg.frame_size;
                    o_drop_next  = drop_now;
                    prev_ts_next = ts_fix;
                    prev_ok_next = 1'b1;
                    burst_next   = burst_tmp;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            dgo_reg     <= 1'b0;
            trig_reg    <= 1'b0;
            burst_reg   <= '0;
            prev_ts_reg <= '0;
            prev_ok_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            dgo_reg     <= dgo_next;
            trig_reg    <= trig_next;
            burst_reg   <= burst_next;
            prev_ts_reg <= prev_ts_next;
            prev_ok_reg <= prev_ok_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        period_reg <= period_next;
        x_reg      <= x_next;
        w_reg      <= w_next;
        acc_reg    <= acc_next;
        ts_reg     <= ts_next;
        o_id_reg   <= o_id_next;
        o_ts_reg   <= o_ts_next;
        o_size_reg <= o_size_next;
        o_drop_reg <= o_drop_next;
    end

    assign out_valid    = ov_reg;
    assign frame_number = o_id_reg;
    assign timestamp_ns = $signed(o_ts_reg);
    assign frame_bytes  = o_size_reg;
    assign dropped      = o_drop_reg;
endmodule

@@ hdl/frame_drop_jitter_generator.sv @@
// Top level of the frame drop and jitter generator.
//
// Each input transaction is one frame tick; each produces exactly one output
// transaction carrying the frame id, a timestamp in ns relative to stream
// start (period times id plus a hashed jitter within +/- max_jitter_us,
// set 1 us past the previous frame of the pull if not later), the size and a
// drop flag. A front part assigns ids and queues frames; a back part works on
// one frame at a time with one shared bit-serial divider and one shared
// 64x16 multiplier that builds each 64-bit product chunk by chunk. The
// period divide, and the jitter and periodic modulo when enabled, each cost
// one divider pass; the timestamp takes one product of period and id, each
// hash adds two mix products to the shared id product, and the percentage
// modulo folds the hash by residues. The queue holds up to QUEUE_DEPTH
// frames, and a finished frame waits in the output register while the next
// is worked.
// Configuration is a 64-bit APB port, register i at byte address 8*i; write
// registers only while no frame is in flight.
module frame_drop_jitter_generator #(
    parameter int QUEUE_DEPTH = fdj_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fdj_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    // frame tick input
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        restart_stream,
    input  logic                        first_of_pull,
    // frame result output
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [63:0]                 frame_number,
    output logic signed [63:0]          timestamp_ns,
    output logic [31:0]                 frame_bytes,
    output logic                        dropped
);
    fdj_pkg::cfg_t        cfg_reg;
    fdj_pkg::frame_item_t push_item, pop_item;
    logic                 push, pop, q_full, q_not_empty;
    logic                 wr_en;
    logic [2:0]           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[5:3];

    // register file: hold values, mask writes to each field's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frames_per_second      <= 17'd30;
            cfg_reg.max_jitter_us          <= '0;
            cfg_reg.frame_size             <= 32'd1048576;
            cfg_reg.hash_seed              <= 64'd1;
            cfg_reg.periodic_drop_interval <= '0;
            cfg_reg.drop_chance_percent    <= '0;
            cfg_reg.burst_length           <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                fdj_pkg::REG_FPS:      cfg_reg.frames_per_second      <= pwdata[16:0];
                fdj_pkg::REG_JITTER:   cfg_reg.max_jitter_us          <= pwdata[19:0];
                fdj_pkg::REG_SIZE:     cfg_reg.frame_size             <= pwdata[31:0];
                fdj_pkg::REG_SEED:     cfg_reg.hash_seed              <= pwdata;
                fdj_pkg::REG_INTERVAL: cfg_reg.periodic_drop_interval <= pwdata[15:0];
                fdj_pkg::REG_PERCENT:  cfg_reg.drop_chance_percent    <= pwdata[6:0];
                fdj_pkg::REG_BURST:    cfg_reg.burst_length           <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            fdj_pkg::REG_FPS:      prdata = 64'(cfg_reg.frames_per_second);
            fdj_pkg::REG_JITTER:   prdata = 64'(cfg_reg.max_jitter_us);
            fdj_pkg::REG_SIZE:     prdata = 64'(cfg_reg.frame_size);
            fdj_pkg::REG_SEED:     prdata = cfg_reg.hash_seed;
            fdj_pkg::REG_INTERVAL: prdata = 64'(cfg_reg.periodic_drop_interval);
            fdj_pkg::REG_PERCENT:  prdata = 64'(cfg_reg.drop_chance_percent);
            fdj_pkg::REG_BURST:    prdata = 64'(cfg_reg.burst_length);
            default:               prdata = '0;
        endcase
    end

    // front: accept ticks, assign ids
    fdj_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .restart_stream(restart_stream),
        .first_of_pull (first_of_pull),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    // decouple front from back
    fdj_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .full     (q_full),
        .pop      (pop),
        .pop_item (pop_item),
        .not_empty(q_not_empty)
    );

    // back: timestamp, jitter, drop decision and output register
    fdj_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (pop_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_number(frame_number),
        .timestamp_ns(timestamp_ns),
        .frame_bytes (frame_bytes),
        .dropped     (dropped)
    );
endmodule

@@ tb/frame_drop_jitter_generator_checker.sv @@
// Checker: watches the frame tick and frame result channels, predicts and compares.
module frame_drop_jitter_generator_checker
    import fdj_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr,
    input  logic [2:0]         cfg_idx,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               restart_stream,
    input  logic               first_of_pull,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [63:0]        frame_number,
    input  logic signed [63:0] timestamp_ns,
    input  logic [31:0]        frame_bytes,
    input  logic               dropped,
    output int                 fail_count,
    output int                 pending,
    output int                 frames_seen,
    output int                 drops_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] id;
        logic [63:0] ts;
        logic [31:0] size;
        logic        drop;
    } frame_result_t;

    cfg_t          cfg;
    logic [63:0]   next_id;
    logic [15:0]   burst_owed;
    logic [63:0]   last_ts;
    logic          last_ts_ok;
    frame_result_t expected_frames[$];

    function automatic logic [63:0] splitmix(input logic [63:0] v);
        logic [63:0] s;
        s = v + GOLDEN_INC;
        s = (s ^ (s >> 30)) * MIX_MUL_A;
        s = (s ^ (s >> 27)) * MIX_MUL_B;
        return s ^ (s >> 31);
    endfunction

    // Advance the frame model by one tick and queue its expected result.
    task automatic predict_frame(input logic restart, input logic first);
        logic [63:0]   fps, period, id, jit, h, span, mj;
        logic          trig;
        frame_result_t r;
        fps = (cfg.frames_per_second == 0) ? 64'd1 : 64'(cfg.frames_per_second);
        period = NS_PER_S / fps;
        if (period == 0)
            period = 1;
        if (restart)
            next_id = 0;
        if (first)
        begin
            burst_owed = 0;
            last_ts = 0;
            last_ts_ok = 0;
        end
        id = next_id;
        next_id = id + 1;
        mj = 64'(cfg.max_jitter_us);
        jit = 0;
        if (mj != 0)
        begin
            h = splitmix(cfg.hash_seed ^ (id * GOLDEN_INC));
            span = mj * 2 + 1;
            jit = (h % span) - mj;
        end
        r.ts = period * id + jit * 64'd1000;
        if (last_ts_ok && $signed(r.ts) <= $signed(last_ts))
            r.ts = last_ts + 64'd1000;
        last_ts = r.ts;
        last_ts_ok = 1;
        trig = (cfg.periodic_drop_interval != 0)
            && (((id + 1) % 64'(cfg.periodic_drop_interval)) == 0);
        if (cfg.drop_chance_percent >= PERCENT_ALL)
            trig = 1;
        else if (cfg.drop_chance_percent != 0)
        begin
            h = splitmix((cfg.hash_seed ^ DROP_SALT) + id * GOLDEN_INC);
            if ((h % 64'd100) < 64'(cfg.drop_chance_percent))
                trig = 1;
        end
        if (cfg.burst_length != 0 && trig && burst_owed < cfg.burst_length)
            burst_owed = cfg.burst_length;
        r.drop = trig;
        if (cfg.burst_length != 0 && burst_owed != 0)
        begin
            r.drop = 1;
            burst_owed = burst_owed - 1;
        end
        r.id = id;
        r.size = r.drop ? 32'd0 : cfg.frame_size;
        expected_frames.insert(expected_frames.size(), r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t e;
        if (!rst_n)
        begin
            cfg <= '{17'd30, 20'd0, 32'd1048576, 64'd1, 16'd0, 7'd0, 16'd0};
            next_id = 0;
            burst_owed = 0;
            last_ts = 0;
            last_ts_ok = 0;
            expected_frames.delete();
            fail_count <= 0;
            pending <= 0;
            frames_seen <= 0;
            drops_seen <= 0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_FPS:      cfg.frames_per_second <= cfg_data[16:0];
                    REG_JITTER:   cfg.max_jitter_us <= cfg_data[19:0];
                    REG_SIZE:     cfg.frame_size <= cfg_data[31:0];
                    REG_SEED:     cfg.hash_seed <= cfg_data;
                    REG_INTERVAL: cfg.periodic_drop_interval <= cfg_data[15:0];
                    REG_PERCENT:  cfg.drop_chance_percent <= cfg_data[6:0];
                    REG_BURST:    cfg.burst_length <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_frame(restart_stream, first_of_pull);
            if (out_valid && !out_stall)
            begin
                frames_seen <= frames_seen + 1;
                drops_seen <= drops_seen + int'(dropped);
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: unexpected frame result id=%0d", $time, frame_number);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_frames.pop_front();
                    if (e.id !== frame_number || e.ts !== timestamp_ns
                        || e.size !== frame_bytes || e.drop !== dropped)
                    begin
                        $display("%0t: mismatch expected id=%0d ts=%0d size=%0d drop=%0b",
                                 $time, e.id, $signed(e.ts), e.size, e.drop);
                        $display("%0t:          actual   id=%0d ts=%0d size=%0d drop=%0b",
                                 $time, frame_number, timestamp_ns, frame_bytes, dropped);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_frames.size();
        end
    end
endmodule

@@ tb/frame_drop_jitter_generator_tb.sv @@
// Testbench top: drives frame ticks and register writes, gives the verdict.
module frame_drop_jitter_generator_tb;
    import fdj_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [63:0]        pwdata, prdata;
    logic               pready;
    logic               in_valid, in_stall, restart_stream, first_of_pull;
    logic               out_valid, out_stall;
    logic [63:0]        frame_number;
    logic signed [63:0] timestamp_ns;
    logic [31:0]        frame_bytes;
    logic               dropped;
    int                 fail_count, pending, frames_seen, drops_seen;
    longint             cycles;
    int                 phases_run;

    frame_drop_jitter_generator dut (.*);

    frame_drop_jitter_generator_checker chk (
        .clk, .rst_n,
        .cfg_wr(psel && penable && pwrite && pready),
        .cfg_idx(paddr[5:3]), .cfg_data(pwdata),
        .in_valid, .in_stall, .restart_stream, .first_of_pull,
        .out_valid, .out_stall, .frame_number, .timestamp_ns, .frame_bytes, .dropped,
        .fail_count, .pending, .frames_seen, .drops_seen
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("frame_drop_jitter_generator_tb NOT OK");
            $finish;
        end
    end

    // Receiver side: stall for a random number of cycles per result, with
    // stall-free stretches in between.
    initial
    begin
        int wait_n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            repeat (wait_n) @(posedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            out_stall <= 1'b1;
        end
    end

    // Write one register: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 3'b000});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Hold until every expected result has come, then let the back part settle.
    task automatic drain;
        while (pending != 0 || in_valid)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // Send one frame tick; valid stays up across back-to-back ticks.
    task automatic send_tick(input logic restart, input logic first, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart_stream <= restart;
        first_of_pull <= first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic random_ticks(input int n);
        int gap;
        for (int k = 0; k < n; k++)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            send_tick($urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0, gap);
        end
        in_valid <= 1'b0;
    endtask

    // Apply one full register set while the block is idle.
    task automatic configure(input logic [16:0] fps, input logic [19:0] jit,
                             input logic [31:0] size, input logic [63:0] seed,
                             input logic [15:0] interval, input logic [6:0] pct,
                             input logic [15:0] burst);
        drain();
        write_reg(REG_FPS, 64'(fps));
        write_reg(REG_JITTER, 64'(jit));
        write_reg(REG_SIZE, 64'(size));
        write_reg(REG_SEED, seed);
        write_reg(REG_INTERVAL, 64'(interval));
        write_reg(REG_PERCENT, 64'(pct));
        write_reg(REG_BURST, 64'(burst));
        phases_run++;
    endtask

    initial
    begin
        cycles = 0;
        phases_run = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        restart_stream = 1'b0;
        first_of_pull = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values first, then restart and pull boundaries.
        send_tick(1'b0, 1'b0, 0);
        send_tick(1'b0, 1'b0, 0);
        send_tick(1'b1, 1'b0, 0);
        send_tick(1'b0, 1'b1, 2);
        send_tick(1'b1, 1'b1, 0);
        in_valid <= 1'b0;

        // Zero rate acts as one; large negative jitter forces the rising-timestamp
        // fix-up; every frame dropped at 100 percent and beyond.
        configure(17'd0, 20'hFFFFF, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 16'd1, 7'd100, 16'd0);
        send_tick(1'b1, 1'b1, 0);
        send_tick(1'b0, 1'b0, 0);
        send_tick(1'b0, 1'b0, 0);
        in_valid <= 1'b0;
        configure(17'h1FFFF, 20'd1000000, 32'd1, 64'd0, 16'hFFFF, 7'h7F, 16'hFFFF);
        send_tick(1'b1, 1'b1, 0);
        send_tick(1'b0, 1'b0, 0);
        send_tick(1'b0, 1'b1, 0);
        in_valid <= 1'b0;

        // Burst owed, then bursts turned off: owed count must stay unused.
        configure(17'd100000, 20'd0, 32'd1234, 64'd7, 16'd3, 7'd0, 16'd5);
        for (int k = 0; k < 5; k++)
            send_tick(k == 0, 1'b0, 0);
        in_valid <= 1'b0;
        configure(17'd100000, 20'd0, 32'd1234, 64'd7, 16'd0, 7'd0, 16'd0);
        send_tick(1'b0, 1'b0, 0);
        send_tick(1'b0, 1'b0, 0);
        in_valid <= 1'b0;

        // Random phases: mostly realistic rates, several register settings.
        for (int p = 0; p < 10; p++)
        begin
            configure(17'($urandom_range(1, 100000)),
                      ($urandom_range(0, 2) == 0) ? 20'd0 : 20'($urandom_range(0, 20'hFFFFF)),
                      $urandom, {$urandom, $urandom},
                      ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 9))
                                                  : 16'($urandom),
                      7'($urandom_range(0, 127)),
                      ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 6))
                                                  : 16'($urandom));
            random_ticks(143);
        end

        drain();
        $display("covered %0d frames (%0d dropped) over %0d register settings",
                 frames_seen, drops_seen, phases_run);
        if (fail_count == 0)
            $display("frame_drop_jitter_generator_tb OK");
        else
            $display("frame_drop_jitter_generator_tb NOT OK");
        $finish;
    end
endmodule
